@@ rtl/u8dec_pkg.sv @@
// u8dec_pkg: shared types, constants and decode functions of the utf-8 stream decoder
// no dependencies; imported by u8dec_front, u8dec_emit and utf8_stream_decoder
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned OUT_W   = 40;

  localparam logic [CNT_W-1:0] MAX_CHARS = CNT_W'(4096);

  localparam logic [CP_W-1:0] CP_REPL    = CP_W'(24'h00FFFD);
  localparam logic [CP_W-1:0] CP_MAX_BMP = CP_W'(24'h00FFFF);
  localparam logic [CP_W-1:0] CP_MAX_LAT = CP_W'(24'h0000FF);

  localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

  localparam logic [CLASS_W-1:0] CLASS_NARROW = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_BMP    = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_WIDE   = 3'd4;

  typedef struct packed {
    logic [1:0]                 n;
    logic [MAX_RES-1:0][CP_W-1:0] cp;
    logic                       eos;
  } burst_t;

  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] c);
    logic [2:0] len;
    len = 3'd1;
    if ((c & LEAD2_MASK) == LEAD2_PAT) len = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_PAT) len = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_PAT) len = 3'd4;
    return len;
  endfunction

  function automatic logic [CP_W-1:0] utf_decode(input logic [BYTE_W-1:0] c0,
                                                 input logic [BYTE_W-1:0] c1,
                                                 input logic [BYTE_W-1:0] c2,
                                                 input logic [BYTE_W-1:0] c3,
                                                 input logic [2:0]        avail);
    logic [CP_W-1:0] cp;
    cp = CP_REPL;
    if (c0 < ASCII_LIM)
      cp = {13'd0, c0};
    else if ((c0 & LEAD2_MASK) == LEAD2_PAT && avail >= 3'd2)
      cp = {10'd0, c0[4:0], c1[5:0]};
    else if ((c0 & LEAD3_MASK) == LEAD3_PAT && avail >= 3'd3)
      cp = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
    else if ((c0 & LEAD4_MASK) == LEAD4_PAT && avail >= 3'd4)
      cp = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
    return cp;
  endfunction

endpackage

@@ rtl/u8dec_front.sv @@
// u8dec_front: holds the bytes of an unfinished sequence and decodes each accepted byte
// into a burst of zero to three code points; depends on u8dec_pkg
module u8dec_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [u8dec_pkg::BYTE_W-1:0]  data_byte,
  input  logic                          end_of_string,
  output u8dec_pkg::burst_t             burst
);
  import u8dec_pkg::*;

  logic [1:0]              held_r, held_nxt;
  logic [2:0]              exp_r, exp_nxt;
  logic [2:0][BYTE_W-1:0]  pend_r, pend_nxt;

  logic [3:0][BYTE_W-1:0]  b;
  logic [2:0]              total;
  logic [2:0]              need;
  logic                    complete;
  logic                    held_two;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < held_r) b[k] = pend_r[k];
      else if (2'(k) == held_r) b[k] = data_byte;
      else b[k] = '0;
    end
    b[3] = (held_r == 2'd3) ? data_byte : '0;

    total    = {1'b0, held_r} + 3'd1;
    need     = (held_r == 2'd0) ? lead_len(data_byte) : exp_r;
    complete = (total >= need);
    held_two = (held_r == 2'd2);

    burst     = '0;
    burst.eos = end_of_string;
    if (complete) begin
      burst.n     = 2'd1;
      burst.cp[0] = utf_decode(b[0], b[1], b[2], b[3], total);
    end else if (end_of_string) begin
      burst.n     = 2'd1;
      burst.cp[0] = CP_REPL;
      if (held_r != 2'd0) begin
        burst.n     = 2'd2;
        burst.cp[1] = utf_decode(b[1], b[2], '0, '0, {1'b0, held_r});
        if (held_two && !(lead_len(b[1]) == 3'd2)) begin
          burst.n     = 2'd3;
          burst.cp[2] = utf_decode(b[2], '0, '0, '0, 3'd1);
        end
      end
    end

    held_nxt = held_r;
    exp_nxt  = exp_r;
    pend_nxt = pend_r;
    if (accept) begin
      if (complete || end_of_string) begin
        held_nxt = 2'd0;
        exp_nxt  = 3'd0;
      end else begin
        pend_nxt[held_r] = data_byte;
        held_nxt         = total[1:0];
        exp_nxt          = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      exp_r  <= 3'd0;
    end else begin
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

@@ rtl/u8dec_emit.sv @@
// u8dec_emit: burst register, running character count and width class, output register
// depends on u8dec_pkg
module u8dec_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  u8dec_pkg::burst_t             burst,
  output logic                          burst_ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [u8dec_pkg::OUT_W-1:0]   out_tdata,
  output logic                          out_tlast
);
  import u8dec_pkg::*;

  logic [1:0]                   rem_r, rem_nxt;
  logic [MAX_RES-1:0][CP_W-1:0] cp_r, cp_nxt;
  logic                         eos_r, eos_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt, cnt_inc;
  logic [CLASS_W-1:0]           cls_r, cls_nxt, cls_upd;
  logic                         ovalid_r, ovalid_nxt;
  logic [CP_W-1:0]              ocp_r, ocp_nxt;
  logic [CNT_W-1:0]             ocnt_r, ocnt_nxt;
  logic [CLASS_W-1:0]           ocls_r, ocls_nxt;
  logic                         olast_r, olast_nxt;

  logic drain;
  logic last_of_burst;
  logic final_res;

  assign drain         = (rem_r != 2'd0) && (!ovalid_r || out_tready);
  assign last_of_burst = (rem_r == 2'd1);
  assign final_res     = eos_r && last_of_burst;
  assign burst_ready   = (rem_r == 2'd0) || (last_of_burst && drain);

  always_comb begin
    cnt_inc = (cnt_r < MAX_CHARS) ? cnt_r + CNT_W'(1) : cnt_r;
    cls_upd = cls_r;
    if (cp_r[0] > CP_MAX_BMP) cls_upd = CLASS_WIDE;
    else if (cp_r[0] > CP_MAX_LAT && cls_r != CLASS_WIDE) cls_upd = CLASS_BMP;

    rem_nxt = rem_r;
    cp_nxt  = cp_r;
    eos_nxt = eos_r;
    if (load) begin
      rem_nxt = burst.n;
      cp_nxt  = burst.cp;
      eos_nxt = burst.eos;
    end else if (drain) begin
      rem_nxt = rem_r - 2'd1;
      cp_nxt  = {{CP_W{1'b0}}, cp_r[MAX_RES-1:1]};
    end

    cnt_nxt    = cnt_r;
    cls_nxt    = cls_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ocp_nxt    = ocp_r;
    ocnt_nxt   = ocnt_r;
    ocls_nxt   = ocls_r;
    olast_nxt  = olast_r;
    if (drain) begin
      ovalid_nxt = 1'b1;
      ocp_nxt    = cp_r[0];
      ocnt_nxt   = cnt_inc;
      ocls_nxt   = cls_upd;
      olast_nxt  = final_res;
      cnt_nxt    = final_res ? '0 : cnt_inc;
      cls_nxt    = final_res ? CLASS_NARROW : cls_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= 2'd0;
      cnt_r    <= '0;
      cls_r    <= CLASS_NARROW;
      ovalid_r <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      cls_r    <= cls_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cp_r    <= cp_nxt;
    eos_r   <= eos_nxt;
    ocp_r   <= ocp_nxt;
    ocnt_r  <= ocnt_nxt;
    ocls_r  <= ocls_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_W-CP_W-CNT_W-CLASS_W){1'b0}}, ocls_r, ocnt_r, ocp_r};
  assign out_tlast  = olast_r;

`ifndef NO_ASSERTIONS
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (drain && final_res) |=> (cnt_r == '0 && cls_r == CLASS_NARROW))
    else $error("string state not cleared after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ocnt_r <= MAX_CHARS && ocnt_r != '0))
    else $error("character total out of range");

  a_class_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> ($onehot(ocls_r) && ocls_r != 3'd0))
    else $error("width class not 1, 2 or 4");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (load && burst.eos) |-> (burst.n != 2'd0))
    else $error("end of string produced no result");
`endif

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level of the lenient utf-8 to code point decoder
// depends on u8dec_pkg, u8dec_front and u8dec_emit
//
// usage:
//   in_* takes one byte per transaction; in_tlast marks the last byte of a string.
//   out_* gives one decoded character per transaction with the running character
//   count and the widest width class of the string; out_tlast marks the last
//   character of the string, where the count and class are final.
//   a byte that completes a character passes the burst and output registers to
//   out_*. bytes inside a multi-byte sequence give no result. a string that ends
//   inside a sequence gives up to three results from its last byte, which are
//   drained one per cycle from the burst register while the receiver keeps up;
//   in_tready stays low until the last one drains. when the receiver stalls, the
//   output register holds its transaction and one more burst waits in the burst
//   register before in_tready goes low. outside such a flush and while the
//   receiver keeps up, throughput is one byte and at most one result per cycle.
//   reset (rst_n low, synchronous) drops any partial sequence and clears the
//   count to zero and the width class to 1.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [20:0] code_point, [33:21] char_total, [36:34] width_class
  output logic        out_tlast
);
  import u8dec_pkg::*;

  burst_t burst;
  logic   burst_ready;
  logic   accept;
  logic   load;

  assign in_tready = burst_ready;
  assign accept    = in_tvalid && burst_ready;
  assign load      = accept && (burst.n != 2'd0);

  u8dec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .end_of_string (in_tlast),
    .burst         (burst)
  );

  u8dec_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .burst       (burst),
    .burst_ready (burst_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
